// ===== sv/mspd_pkg.sv =====
// ----------------------------------------------------------------------------
// mspd_pkg
// Shared widths, register indexes and reset values of the strike peak detector.
// ----------------------------------------------------------------------------
package mspd_pkg;

   // Port widths
   localparam int CHAN_W      = 3;
   localparam int SAMPLE_W    = 12;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int WINDOW_W    = 20;

   // Number of threshold registers in the register map
   localparam int NUM_THRESH  = 6;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_CH0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_CH5  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CAPTURE_WINDOW = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RECOVERY_WINDOW = 3'd7;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET       = 12'd200;
   localparam logic [WINDOW_W-1:0] CAPTURE_WINDOW_RESET  = 20'd3000;
   localparam logic [WINDOW_W-1:0] RECOVERY_WINDOW_RESET = 20'd50000;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [WINDOW_W-1:0] window_type;

endpackage

// ===== sv/multichannel_strike_peak_detector.sv =====
// ----------------------------------------------------------------------------
// multichannel_strike_peak_detector
// Per-channel strike capture: threshold trigger, peak hold, retrigger mask.
// ----------------------------------------------------------------------------
// Takes one ADC sample transaction per clock (channel, 12-bit sample, 32-bit
// microsecond timestamp) and produces at most one hit transaction (channel,
// peak) per sample. An accepted sample lands in the input register, and
// its hit is loaded into the result register when that register is free
// or being drained; the hit then shows on rsp_*. The per-channel state
// lookup, deadline compares and update sit between the two registers.
// Throughput is one sample per clock as long as rsp_stall is low; a
// stalled hit holds the result register, and a second sample waits in the
// input register before req_stall is raised. Samples for a channel at or
// above CHANNELS, and samples that land before the channel's recovery
// deadline, change nothing. Deadlines are compared wrap-safe on the sign of
// (now - deadline) taken modulo 2^TIME_BITS. Right after reset all recovery
// deadlines are zero, so timestamps in the upper half of the time range are
// masked until the first hit of that channel. Registers: index 0..5
// thresholds (12 bit), 6 capture window, 7 recovery window (20 bit, us).
// The register port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module multichannel_strike_peak_detector #(
   parameter int CHANNELS    = 6,
   parameter int SAMPLE_BITS = 12,
   parameter int TIME_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample transactions
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mspd_pkg::CHAN_W-1:0]          req_channel,
   input  logic [mspd_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic [mspd_pkg::TIME_W-1:0]          req_time_us,
   // hit transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mspd_pkg::CHAN_W-1:0]          rsp_hit_channel,
   output logic [mspd_pkg::SAMPLE_W-1:0]        rsp_hit_peak,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mspd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mspd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Effective sample width: port carries 12 bits, SAMPLE_BITS may trim it.
   localparam int SW = (SAMPLE_BITS < mspd_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                         : mspd_pkg::SAMPLE_W;
   localparam logic [mspd_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      mspd_pkg::SAMPLE_W'((64'd1 << SW) - 64'd1);
   localparam int TW       = TIME_BITS;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [mspd_pkg::CHAN_W-1:0] CHAN_LIMIT = mspd_pkg::CHAN_W'(CHANNELS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   mspd_pkg::sample_type threshold_ff [mspd_pkg::NUM_THRESH];
   mspd_pkg::window_type capture_window_ff;
   mspd_pkg::window_type recovery_window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mspd_pkg::NUM_THRESH; i++) begin
            threshold_ff[i] <= mspd_pkg::THRESHOLD_RESET;
         end
         capture_window_ff  <= mspd_pkg::CAPTURE_WINDOW_RESET;
         recovery_window_ff <= mspd_pkg::RECOVERY_WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            [mspd_pkg::REG_THRESHOLD_CH0:mspd_pkg::REG_THRESHOLD_CH5]: begin
               threshold_ff[csr_index] <= csr_wdata[mspd_pkg::SAMPLE_W-1:0];
            end
            mspd_pkg::REG_CAPTURE_WINDOW: begin
               capture_window_ff <= csr_wdata[mspd_pkg::WINDOW_W-1:0];
            end
            mspd_pkg::REG_RECOVERY_WINDOW: begin
               recovery_window_ff <= csr_wdata[mspd_pkg::WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   logic [mspd_pkg::CHAN_W-1:0]          s1_channel_ff;
   logic [mspd_pkg::SAMPLE_W-1:0]        s1_sample_ff;
   logic [TW-1:0]                        s1_time_ff;
   logic                                 advance;
   logic                                 req_take;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [mspd_pkg::CHAN_W-1:0]          rsp_channel_ff;
   logic [mspd_pkg::SAMPLE_W-1:0]        rsp_peak_ff;

   // The input register moves on whenever the result register is free or
   // being drained this cycle.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample & SAMPLE_MASK;
         s1_time_ff    <= req_time_us[TW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Per-channel state and update
   // ---------------------------------------------------------------------
   logic                          armed_ff       [CHANNELS];
   logic [mspd_pkg::SAMPLE_W-1:0] peak_ff        [CHANNELS];
   logic [TW-1:0]                 cap_deadline_ff[CHANNELS];
   logic [TW-1:0]                 rec_deadline_ff[CHANNELS];

   logic [CH_IDX_W-1:0]           ch_idx;
   logic                          in_range;
   logic                          cur_armed;
   logic [mspd_pkg::SAMPLE_W-1:0] cur_peak;
   logic [mspd_pkg::SAMPLE_W-1:0] cur_threshold;
   logic [TW-1:0]                 rec_diff;
   logic [TW-1:0]                 cap_diff;
   logic                          live;
   logic                          trigger;
   logic                          emit;
   logic                          update;
   logic                          armed_in;
   logic [mspd_pkg::SAMPLE_W-1:0] peak_in;
   logic [TW-1:0]                 cap_deadline_in;
   logic [TW-1:0]                 rec_deadline_in;

   assign ch_idx   = s1_channel_ff[CH_IDX_W-1:0];
   assign in_range = s1_channel_ff < CHAN_LIMIT;

   always_comb begin
      cur_armed     = 1'b1;
      cur_peak      = '0;
      cur_threshold = '0;
      rec_diff      = '0;
      cap_diff      = '0;
      if (in_range) begin
         cur_armed     = armed_ff[ch_idx];
         cur_peak      = peak_ff[ch_idx];
         cur_threshold = threshold_ff[s1_channel_ff];
         rec_diff      = s1_time_ff - rec_deadline_ff[ch_idx];
         cap_diff      = s1_time_ff - cap_deadline_ff[ch_idx];
      end
   end

   // Sign bit of (now - deadline) set means still before the deadline.
   assign live    = s1_valid_ff && in_range && !rec_diff[TW-1];
   assign trigger = live && cur_armed && (s1_sample_ff > cur_threshold);
   assign emit    = live && !cur_armed && !cap_diff[TW-1];
   assign update  = advance && (trigger || (live && !cur_armed));

   always_comb begin
      armed_in        = cur_armed;
      peak_in         = cur_peak;
      cap_deadline_in = s1_time_ff + TW'(capture_window_ff);
      rec_deadline_in = s1_time_ff + TW'(recovery_window_ff);
      if (trigger) begin
         armed_in = 1'b0;
         peak_in  = s1_sample_ff;
      end else begin
         if (s1_sample_ff > cur_peak) begin
            peak_in = s1_sample_ff;
         end
         if (emit) begin
            armed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            armed_ff[i]        <= 1'b1;
            peak_ff[i]         <= '0;
            cap_deadline_ff[i] <= '0;
            rec_deadline_ff[i] <= '0;
         end
      end else if (update) begin
         armed_ff[ch_idx] <= armed_in;
         peak_ff[ch_idx]  <= peak_in;
         if (trigger) begin
            cap_deadline_ff[ch_idx] <= cap_deadline_in;
         end
         if (emit) begin
            rec_deadline_ff[ch_idx] <= rec_deadline_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_peak_ff    <= peak_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_channel = rsp_channel_ff;
   assign rsp_hit_peak    = rsp_peak_ff;

endmodule

// ===== sv/mspd_checker.sv =====
// ----------------------------------------------------------------------------
// mspd_checker
// Port-level checks for the strike peak detector, bound to the top level.
// ----------------------------------------------------------------------------
module mspd_checker #(
   parameter int CHANNELS = 6
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [mspd_pkg::CHAN_W-1:0]     rsp_hit_channel,
   input logic [mspd_pkg::SAMPLE_W-1:0]   rsp_hit_peak
);

   // A stalled hit transaction stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_channel)
                                 && $stable(rsp_hit_peak))
      else $error("hit transaction changed while stalled");

   // Only configured channels report hits.
   a_hit_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_channel < mspd_pkg::CHAN_W'(CHANNELS))
      else $error("hit on a channel outside the configured range");

   // A fresh hit comes from an earlier accepted sample, passed on through the input register.
   a_hit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("hit without a sample two clocks earlier");

   // Input back-pressure only while a hit is held on the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("sample stalled without a stalled hit");

endmodule

bind multichannel_strike_peak_detector mspd_checker #(.CHANNELS(CHANNELS)) u_mspd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit_channel (rsp_hit_channel),
   .rsp_hit_peak    (rsp_hit_peak)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel strike peak detector.
// ----------------------------------------------------------------------------
// Sample transactions go in on req_*, hit transactions are checked on rsp_*.
// A shadow of the per-channel state (armed flag, running peak, capture and
// recovery deadlines) follows every accepted sample and queues each hit it
// predicts. Each accepted hit is compared in order. Directed tests cover
// the reset mask, threshold edges, zero and 1000000 us windows and ignored
// channels. Random phases run under several register settings with bursty
// sender traffic, receiver stall patterns, a long receiver hold-off and
// a sender pause.
// ----------------------------------------------------------------------------
module tb;

   localparam int SETTLE_CYCLES  = 4;       // covers the two-stage pipe
   localparam int HOLDOFF_CYCLES = 250;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_ITEMS    = 190;

   typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct packed {
      logic [mspd_pkg::CHAN_W-1:0] channel;
      mspd_pkg::sample_type        peak;
   } strike_hit_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input holds a known value from time zero
   // ------------------------------------------------------------------------
   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   logic [mspd_pkg::CHAN_W-1:0]      req_channel = '0;
   logic [mspd_pkg::SAMPLE_W-1:0]    req_sample  = '0;
   logic [mspd_pkg::TIME_W-1:0]      req_time_us = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   logic [mspd_pkg::CHAN_W-1:0]      rsp_hit_channel;
   logic [mspd_pkg::SAMPLE_W-1:0]    rsp_hit_peak;
   logic                             csr_valid   = 1'b0;
   logic                             csr_ready;
   logic [mspd_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [mspd_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   multichannel_strike_peak_detector uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_time_us     (req_time_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit_channel (rsp_hit_channel),
      .rsp_hit_peak    (rsp_hit_peak),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow state of the detector
   // ------------------------------------------------------------------------
   mspd_pkg::sample_type        trig_level   [mspd_pkg::NUM_THRESH];
   mspd_pkg::window_type        cap_window;
   mspd_pkg::window_type        rec_window;
   bit                          chan_armed   [mspd_pkg::NUM_THRESH];
   mspd_pkg::sample_type        chan_peak    [mspd_pkg::NUM_THRESH];
   logic [mspd_pkg::TIME_W-1:0] cap_deadline [mspd_pkg::NUM_THRESH];
   logic [mspd_pkg::TIME_W-1:0] rec_deadline [mspd_pkg::NUM_THRESH];

   strike_hit_type pending_hits [$];   // hits predicted, not yet seen on rsp_*
   int             error_count = 0;

   // Register plan used by the next load_config call
   mspd_pkg::sample_type plan_level [mspd_pkg::NUM_THRESH];
   mspd_pkg::window_type plan_cap;
   mspd_pkg::window_type plan_rec;

   // Stimulus controls
   logic [mspd_pkg::TIME_W-1:0] now_us      = '0;    // running timestamp of the sensor
   int                          burst_left  = 0;
   bit                          sender_gaps = 1'b1;
   rx_mode_type                 rx_mode     = RX_RANDOM;
   logic [15:0]                 rx_pattern  = 16'h0f35;
   int                          holdoff_count = 0;    // bumped by a test to ask a hold-off

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   // Wrap-safe "now is before the deadline": sign of the modular difference.
   function automatic bit is_early(logic [mspd_pkg::TIME_W-1:0] now,
                                   logic [mspd_pkg::TIME_W-1:0] deadline);
      logic [mspd_pkg::TIME_W-1:0] diff;
      diff = now - deadline;
      return diff[mspd_pkg::TIME_W-1];
   endfunction

   function automatic void clear_shadow();
      for (int c = 0; c < mspd_pkg::NUM_THRESH; c++) begin
         trig_level[c]   = mspd_pkg::THRESHOLD_RESET;
         chan_armed[c]   = 1'b1;
         chan_peak[c]    = '0;
         cap_deadline[c] = '0;
         rec_deadline[c] = '0;
      end
      cap_window = mspd_pkg::CAPTURE_WINDOW_RESET;
      rec_window = mspd_pkg::RECOVERY_WINDOW_RESET;
      pending_hits.delete();
   endfunction

   function automatic void apply_csr(logic [mspd_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [mspd_pkg::CSR_DATA_W-1:0] data);
      if (idx <= mspd_pkg::REG_THRESHOLD_CH5)
         trig_level[idx - mspd_pkg::REG_THRESHOLD_CH0] = data[mspd_pkg::SAMPLE_W-1:0];
      else if (idx == mspd_pkg::REG_CAPTURE_WINDOW)
         cap_window = data[mspd_pkg::WINDOW_W-1:0];
      else if (idx == mspd_pkg::REG_RECOVERY_WINDOW)
         rec_window = data[mspd_pkg::WINDOW_W-1:0];
   endfunction

   // One accepted sample transaction; queues a hit when a capture closes.
   function automatic void predict_strike(logic [mspd_pkg::CHAN_W-1:0] ch,
                                          mspd_pkg::sample_type s,
                                          logic [mspd_pkg::TIME_W-1:0] now);
      strike_hit_type hit;
      if (ch >= mspd_pkg::NUM_THRESH) return;
      if (is_early(now, rec_deadline[ch])) return;   // retrigger mask
      if (!chan_armed[ch]) begin
         if (s > chan_peak[ch]) chan_peak[ch] = s;
         if (!is_early(now, cap_deadline[ch])) begin
            hit.channel = ch;
            hit.peak    = chan_peak[ch];
            pending_hits.push_back(hit);
            chan_armed[ch]   = 1'b1;
            rec_deadline[ch] = now + rec_window;
         end
      end else if (s > trig_level[ch]) begin
         chan_peak[ch]    = s;
         cap_deadline[ch] = now + cap_window;
         chan_armed[ch]   = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: checks hits first (they belong to older samples), then
   // tracks register writes and predicts from accepted samples.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      strike_hit_type want;
      if (reset) begin
         clear_shadow();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hits.size() == 0) begin
               $error("unexpected hit transaction: channel %0d peak %0d",
                      rsp_hit_channel, rsp_hit_peak);
               error_count++;
            end else begin
               want = pending_hits.pop_front();
               if (rsp_hit_channel !== want.channel) begin
                  $error("hit_channel: expected %0d, actual %0d", want.channel,
                         rsp_hit_channel);
                  error_count++;
               end
               if (rsp_hit_peak !== want.peak) begin
                  $error("hit_peak: expected %0d, actual %0d", want.peak, rsp_hit_peak);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) predict_strike(req_channel, req_sample, req_time_us);
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern per mode; a requested hold-off overrides it
   // and is counted here.
   // ------------------------------------------------------------------------
   int       holdoff_taken = 0;
   int       holdoff_left  = 0;
   bit [3:0] rx_phase      = '0;

   always @(negedge clock) begin
      if (holdoff_count != holdoff_taken) begin
         holdoff_taken = holdoff_count;
         holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 40);
            RX_PATTERN: rsp_stall <= rx_pattern[rx_phase];
            default:    rsp_stall <= 1'b0;
         endcase
      end
      rx_phase++;
   end

   // ------------------------------------------------------------------------
   // Drivers; all are entered and left at a falling edge
   // ------------------------------------------------------------------------
   // Sends one sample transaction. Valid stays high on return so the next
   // sample can follow back to back; sender_gaps adds random burst gaps.
   task automatic send_sample(input logic [mspd_pkg::CHAN_W-1:0] ch,
                              input mspd_pkg::sample_type s,
                              input logic [mspd_pkg::TIME_W-1:0] t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = sender_gaps ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= s;
      req_time_us <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [mspd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mspd_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes every register from the plan; junk above bit 11 of each
   // threshold checks that the upper write bits are dropped.
   task automatic load_config();
      logic [mspd_pkg::CSR_DATA_W-1:0] wd;
      for (int c = 0; c < mspd_pkg::NUM_THRESH; c++) begin
         wd = mspd_pkg::CSR_DATA_W'($urandom);
         wd[mspd_pkg::SAMPLE_W-1:0] = plan_level[c];
         write_csr(mspd_pkg::REG_THRESHOLD_CH0 + mspd_pkg::CSR_INDEX_W'(c), wd);
      end
      write_csr(mspd_pkg::REG_CAPTURE_WINDOW, plan_cap);
      write_csr(mspd_pkg::REG_RECOVERY_WINDOW, plan_rec);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait for every predicted hit to arrive.
   task automatic drain_hits();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_hits.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Fully idle: samples that cause no hit may still sit in the pipe.
   task automatic wait_idle();
      drain_hits();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed traffic on live channels with a moving timestamp;
   // a few percent are long time leaps (walk through the wrap), late
   // timestamps or ignored channels with arbitrary time.
   task automatic send_random_sample(input int unsigned step_max);
      logic [mspd_pkg::CHAN_W-1:0] ch;
      mspd_pkg::sample_type        s;
      logic [mspd_pkg::TIME_W-1:0] t;
      int unsigned                 pick;
      int                          lvl;
      pick = $urandom_range(0, 99);
      if (pick < 3) now_us += $urandom_range(32'h1000_0000, 32'h4000_0000);
      else          now_us += $urandom_range(0, step_max);
      t  = now_us;
      ch = mspd_pkg::CHAN_W'($urandom_range(0, mspd_pkg::NUM_THRESH - 1));
      case ($urandom_range(0, 3))
         0: begin   // close to the threshold, both sides of it
            lvl = int'(plan_level[ch]) + int'($urandom_range(0, 6)) - 3;
            if (lvl < 0) lvl = 0;
            if (lvl > 4095) lvl = 4095;
            s = mspd_pkg::SAMPLE_W'(lvl);
         end
         1:       s = mspd_pkg::SAMPLE_W'($urandom_range(0, 63));
         default: s = mspd_pkg::SAMPLE_W'($urandom_range(0, 4095));
      endcase
      if (pick >= 96) begin
         ch = mspd_pkg::CHAN_W'($urandom_range(mspd_pkg::NUM_THRESH, 7));
         t  = $urandom;
      end else if (pick >= 92) begin
         t = now_us - $urandom_range(0, step_max * 4);
      end
      send_sample(ch, s, t);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset values: upper-half timestamps masked, threshold is strict,
   // default windows, ignored channels, a closing sample never restarts.
   task automatic test_reset_state();
      send_sample(3'd0, 12'd4095, 32'h8000_0000);
      send_sample(3'd3, 12'd4095, 32'hffff_ffff);
      send_sample(3'd6, 12'd4095, 32'd100);
      send_sample(3'd7, 12'd4095, 32'd100);
      send_sample(3'd0, 12'd200,  32'd100);
      send_sample(3'd0, 12'd201,  32'd200);     // capture opens
      send_sample(3'd0, 12'd4095, 32'd3199);
      send_sample(3'd0, 12'd250,  32'd3200);    // closes, no restart
      send_sample(3'd0, 12'd4095, 32'd53199);   // still masked
      send_sample(3'd0, 12'd300,  32'd53200);
      send_sample(3'd0, 12'd100,  32'd56200);   // peak is not lowered
      send_sample(3'd5, 12'd4095, 32'd56300);
      send_sample(3'd5, 12'd0,    32'd59299);
      send_sample(3'd5, 12'd0,    32'd59300);
      wait_idle();
   endtask

   // Thresholds at 0 and 4095, windows at zero and at 1000000 us.
   task automatic test_register_extremes();
      logic [mspd_pkg::TIME_W-1:0] t1;
      for (int c = 0; c < mspd_pkg::NUM_THRESH; c++)
         plan_level[c] = mspd_pkg::SAMPLE_W'($urandom_range(0, 4095));
      plan_level[0] = 12'd0;
      plan_level[1] = 12'd4095;
      plan_level[2] = 12'd4095;
      plan_level[3] = 12'd200;
      plan_cap = '0;
      plan_rec = '0;
      load_config();
      send_sample(3'd1, 12'd4095, 32'd200000);  // nothing exceeds 4095
      send_sample(3'd0, 12'd0,    32'd200000);
      send_sample(3'd0, 12'd1,    32'd200000);  // opens; zero window emits nothing
      send_sample(3'd0, 12'd9,    32'd200000);  // closes at once
      send_sample(3'd0, 12'd7,    32'd200000);  // zero recovery: opens again
      wait_idle();

      plan_cap = 20'd1000000;
      plan_rec = 20'd1000000;
      load_config();
      t1 = 32'd300000;
      send_sample(3'd3, 12'd4095, t1);
      send_sample(3'd3, 12'd0,    t1 + 32'd999999);
      send_sample(3'd3, 12'd0,    t1 + 32'd1000000);
      send_sample(3'd3, 12'd4095, t1 + 32'd1999999);
      send_sample(3'd3, 12'd4095, t1 + 32'd2000000);
      now_us = t1 + 32'd2000000;
      wait_idle();
   endtask

   // Receiver holds off while the sender keeps offering hit-producing
   // pairs, so the result register fills and req_stall rises.
   task automatic test_receiver_holdoff();
      for (int c = 0; c < mspd_pkg::NUM_THRESH; c++) plan_level[c] = '0;
      plan_cap = '0;
      plan_rec = '0;
      load_config();
      rx_mode     = RX_READY;
      sender_gaps = 1'b0;
      holdoff_count++;
      for (int i = 0; i < 60; i++) begin
         now_us += $urandom_range(0, 3);
         send_sample(mspd_pkg::CHAN_W'((i / 2) % mspd_pkg::NUM_THRESH),
                     mspd_pkg::SAMPLE_W'($urandom_range(1, 4095)), now_us);
      end
      wait_idle();
   endtask

   // Sender stops mid-stream until every hit is back, then resumes.
   task automatic test_sender_pause();
      rx_mode     = RX_RANDOM;
      sender_gaps = 1'b1;
      repeat (30) send_random_sample(4);
      drain_hits();
      repeat (30) send_random_sample(4);
      wait_idle();
   endtask

   // Random traffic under four register settings and receiver modes.
   task automatic test_random_traffic();
      int unsigned step_max;
      for (int p = 0; p < 4; p++) begin
         for (int c = 0; c < mspd_pkg::NUM_THRESH; c++)
            plan_level[c] = mspd_pkg::SAMPLE_W'($urandom_range(0, 3000));
         case (p)
            0: begin
               plan_cap = mspd_pkg::WINDOW_W'($urandom_range(0, 64));
               plan_rec = mspd_pkg::WINDOW_W'($urandom_range(0, 256));
            end
            1: begin   // extremes: instant close, no mask
               plan_level[0] = 12'd0;
               plan_level[5] = 12'd4095;
               plan_cap = '0;
               plan_rec = '0;
            end
            2: begin
               plan_cap = mspd_pkg::WINDOW_W'($urandom_range(500000, 1000000));
               plan_rec = 20'd1000000;
            end
            default: begin
               plan_cap = mspd_pkg::WINDOW_W'($urandom_range(0, 2000));
               plan_rec = mspd_pkg::WINDOW_W'($urandom_range(0, 5000));
            end
         endcase
         load_config();
         rx_mode     = rx_mode_type'(p % 3);
         sender_gaps = (p != 1);
         // bit 0 clear keeps the receiver ready at least once per pattern
         rx_pattern  = 16'($urandom) & 16'hfffe;
         // time step scaled to the windows so captures both open and close
         step_max = unsigned'((int'(plan_cap) + int'(plan_rec)) / 16 + 2);
         repeat (PHASE_ITEMS) send_random_sample(step_max);
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_extremes();
      test_receiver_holdoff();
      test_sender_pause();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: a hung handshake or a missing hit ends here.
   initial begin
      for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mspd_pkg.sv
sv/multichannel_strike_peak_detector.sv
sv/mspd_checker.sv
bench/tb.sv
